FILE: src/salc_pkg.sv
// Shared constants, types and codes of the set-associative LRU cache model.
package salc_pkg;

  localparam int SETS       = 128;
  localparam int WAYS       = 4;
  localparam int LINE_BYTES = 32;
  localparam int WORD_BYTES = 4;
  localparam int ADDR_BITS  = 32;

  localparam int OFF_W  = $clog2(LINE_BYTES);
  localparam int SET_W  = $clog2(SETS);
  localparam int TAG_W  = ADDR_BITS - OFF_W - SET_W;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int FILL_W = $clog2(WAYS + 1);
  localparam int OPS    = LINE_BYTES / WORD_BYTES;
  localparam int MULT_W = $clog2(2 * OPS + 1);

  localparam int OP_W     = 2;
  localparam int WAYU_W   = 2;
  localparam int CL_W     = 10;
  localparam int ML_W     = 12;
  localparam int BYTES_W  = 7;
  localparam int TIME_W   = 18;
  localparam int OUT_W    = 32;

  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] REG_WR_HIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WR_MISS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CL      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ML      = 2'd3;

  localparam logic [CL_W-1:0] CL_RESET = 10'd5;
  localparam logic [ML_W-1:0] ML_RESET = 12'd200;

  typedef struct packed {
    logic [FILL_W-1:0]             fill;
    logic [WAYS-1:0][WAY_W-1:0]    lru;
    logic [WAYS-1:0]               dirty;
    logic [WAYS-1:0][TAG_W-1:0]    tags;
  } row_t;

  typedef struct packed {
    logic [TIME_W-1:0]  access_time;
    logic [BYTES_W-1:0] bytes_moved;
    logic               dirty_eviction;
    logic [WAYU_W-1:0]  way_used;
    logic               ignored;
    logic               hit;
  } result_t;

endpackage

FILE: src/salc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_r <= mem_r[raddr];
  end

  assign rdata = rd_r;

endmodule

FILE: src/set_assoc_lru_cache_model.sv
// Top level of the set-associative cache model with true LRU replacement.
// An ignored access goes from acceptance through the done state to the output register; a read or
// write goes through set read, tag compare (one way per cycle through the single tag comparator),
// row update and done states. A new access is accepted only while the sequencer is idle.
// Reset clears the sequencer, the output stage, the per-set valid bits and the
// configuration registers; the set RAM holds no reset and needs no clearing pass.
module set_assoc_lru_cache_model (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [salc_pkg::ADDR_BITS-1:0]      in_tdata,   // address
  input  logic [salc_pkg::OP_W-1:0]           in_tuser,   // operation
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // hit, ignored, way_used[1:0], dirty_eviction, bytes_moved[6:0], access_time[17:0], zero pad
  output logic [salc_pkg::OUT_W-1:0]          out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [salc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import salc_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_CMP  = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam result_t RES_IGNORED = '{ignored: 1'b1, default: '0};

  logic [2:0]        state_r, state_nxt;
  logic              wr_hit_r, wr_miss_r;
  logic [CL_W-1:0]   cl_r;
  logic [ML_W-1:0]   ml_r;
  logic [OP_W-1:0]   op_r;
  logic [SET_W-1:0]  set_r;
  logic [TAG_W-1:0]  tag_r;
  logic [WAY_W-1:0]  idx_r;
  logic              hit_r;
  logic [WAY_W-1:0]  way_r;
  logic [SETS-1:0]   set_vld_r;
  result_t           res_r, res_nxt;
  logic              out_valid_r;
  result_t           out_r;

  logic [$bits(row_t)-1:0] ram_rdata;
  row_t              row, row_nxt;
  logic [FILL_W-1:0] fill_eff;
  logic              in_acc, cur_match, cmp_last, ram_we;

  logic              found, ev, full;
  logic [WAY_W-1:0]  pos, victim, way_out;
  logic [MULT_W-1:0] mult_k;
  logic [BYTES_W-1:0] bytes;
  logic [TIME_W-1:0] mem_term, cl_extra;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  salc_ram #(.WIDTH($bits(row_t)), .DEPTH(SETS)) u_set_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (set_r),
    .wdata (row_nxt),
    .raddr (set_r),
    .rdata (ram_rdata)
  );

  assign row      = row_t'(ram_rdata);
  assign fill_eff = set_vld_r[set_r] ? row.fill : '0;
  assign cur_match = (FILL_W'(idx_r) < fill_eff) && (row.tags[idx_r] == tag_r);
  assign cmp_last  = ((FILL_W'(idx_r) + 1'b1) >= fill_eff);
  assign ram_we    = (state_r == ST_UPD);
  assign full      = (fill_eff >= FILL_W'(WAYS));

  always_comb begin
    row_nxt      = row;
    row_nxt.fill = fill_eff;
    found        = 1'b0;
    pos          = '0;
    ev           = 1'b0;
    victim       = '0;
    way_out      = way_r;
    mult_k       = '0;
    bytes        = '0;
    cl_extra     = '0;
    for (int j = 0; j < WAYS; j++) begin
      if (!found && (FILL_W'(j) < fill_eff) && (row.lru[j] == way_r)) begin
        found = 1'b1;
        pos   = WAY_W'(j);
      end
    end
    if (hit_r) begin
      if (op_r == OP_WRITE) begin
        if (!wr_hit_r) begin
          row_nxt.dirty[way_r] = 1'b1;
        end else begin
          bytes  = BYTES_W'(WORD_BYTES);
          mult_k = MULT_W'(1);
        end
      end
      if (found) begin
        for (int j = 0; j < WAYS - 1; j++) begin
          if ((WAY_W'(j) >= pos) && (FILL_W'(j + 1) < fill_eff)) begin
            row_nxt.lru[j] = row.lru[j + 1];
          end
        end
        row_nxt.lru[WAY_W'(fill_eff - 1'b1)] = way_r;
      end
    end else if ((op_r == OP_WRITE) && wr_miss_r) begin
      way_out = '0;
      bytes   = BYTES_W'(WORD_BYTES);
      mult_k  = MULT_W'(1);
    end else begin
      bytes    = BYTES_W'(LINE_BYTES);
      mult_k   = MULT_W'(OPS);
      cl_extra = TIME_W'(cl_r);
      if (full) begin
        victim = row.lru[0];
        if (row.dirty[victim]) begin
          ev     = 1'b1;
          bytes  = BYTES_W'(2 * LINE_BYTES);
          mult_k = MULT_W'(2 * OPS);
        end
        for (int j = 0; j < WAYS - 1; j++) begin
          row_nxt.lru[j] = row.lru[j + 1];
        end
        row_nxt.lru[WAYS-1] = victim;
      end else begin
        victim              = WAY_W'(fill_eff);
        row_nxt.lru[victim] = victim;
        row_nxt.fill        = fill_eff + 1'b1;
      end
      way_out                = victim;
      row_nxt.tags[victim]   = tag_r;
      row_nxt.dirty[victim]  = (op_r == OP_WRITE);
    end
    mem_term = TIME_W'(ml_r) * TIME_W'(mult_k);
    res_nxt.hit            = hit_r;
    res_nxt.ignored        = 1'b0;
    res_nxt.way_used       = WAYU_W'(way_out);
    res_nxt.dirty_eviction = ev;
    res_nxt.bytes_moved    = bytes;
    res_nxt.access_time    = TIME_W'(cl_r) + cl_extra + mem_term;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ((in_tuser == OP_READ) || (in_tuser == OP_WRITE)) ? ST_RD : ST_DONE;
        end
      end
      ST_RD:   state_nxt = ST_CMP;
      ST_CMP: begin
        if (cur_match || cmp_last) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      set_vld_r   <= '0;
      wr_hit_r    <= 1'b0;
      wr_miss_r   <= 1'b0;
      cl_r        <= CL_RESET;
      ml_r        <= ML_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_WR_HIT:  wr_hit_r  <= cfg_data[0];
          REG_WR_MISS: wr_miss_r <= cfg_data[0];
          REG_CL:      cl_r      <= cfg_data[CL_W-1:0];
          REG_ML:      ml_r      <= cfg_data[ML_W-1:0];
        endcase
      end
      if (ram_we) begin
        set_vld_r[set_r] <= 1'b1;
      end
      if ((state_r == ST_DONE) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r        <= in_tuser;
      set_r       <= in_tdata[OFF_W +: SET_W];
      tag_r       <= in_tdata[ADDR_BITS-1 -: TAG_W];
      idx_r       <= '0;
      hit_r       <= 1'b0;
      way_r       <= '0;
      res_r       <= RES_IGNORED;
    end
    if (state_r == ST_CMP) begin
      if (cur_match) begin
        hit_r <= 1'b1;
        way_r <= idx_r;
      end else if (!cmp_last) begin
        idx_r <= idx_r + 1'b1;
      end
    end
    if (state_r == ST_UPD) begin
      res_r <= res_nxt;
    end
    if ((state_r == ST_DONE) && (!out_valid_r || out_tready)) begin
      out_r <= res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_r);

  a_cmp_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> ((FILL_W'(idx_r) < fill_eff) || (fill_eff == '0)))
    else $error("tag compare stepped beyond the filled ways");

  a_accept_route: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> ((state_r == ST_RD) || (state_r == ST_DONE)))
    else $error("accepted access did not start the sequencer");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (row_nxt.fill <= FILL_W'(WAYS)))
    else $error("set fill count exceeds the number of ways");

  a_ignored_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[1]) |-> ((out_tdata[0] == 1'b0) && (out_tdata[29:2] == '0)))
    else $error("ignored access carries nonzero result fields");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench of the set-associative LRU cache model over its stream ports.
`timescale 1ns / 100ps

module testbench;
  import salc_pkg::*;

  localparam logic [OP_W-1:0] OP_OTHER    = 2'd2;
  localparam logic [OP_W-1:0] OP_OTHER_HI = 2'd3;
  localparam int BYTES_SAT = (1 << BYTES_W) - 1;
  localparam int TIME_SAT  = (1 << TIME_W) - 1;

  class lru_cache_scoreboard;
    logic [TAG_W-1:0] line_tag [SETS][WAYS];
    bit               line_dirty [SETS][WAYS];
    int               set_fill [SETS];
    int               lru_list [SETS][WAYS];
    bit               wr_hit_through;
    bit               wr_miss_bypass;
    int               cache_lat;
    int               mem_lat;
    result_t          pending_results [$];
    int               errors;

    function new();
      foreach (set_fill[s]) set_fill[s] = 0;
      foreach (line_dirty[s, w]) line_dirty[s][w] = 1'b0;
      wr_hit_through = 1'b0;
      wr_miss_bypass = 1'b0;
      cache_lat = int'(CL_RESET);
      mem_lat = int'(ML_RESET);
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_WR_HIT:  wr_hit_through = data[0];
        REG_WR_MISS: wr_miss_bypass = data[0];
        REG_CL:      cache_lat = int'(data[CL_W-1:0]);
        REG_ML:      mem_lat = int'(data[ML_W-1:0]);
        default: ;
      endcase
    endfunction

    function int pending_count();
      return pending_results.size();
    endfunction

    // Moves a way to the most recently used end of its set's list.
    function void promote(int s, int w);
      int i;
      int n;
      n = set_fill[s];
      i = 0;
      while (i < n && lru_list[s][i] != w) i++;
      if (i >= n) return;
      while (i + 1 < n) begin
        lru_list[s][i] = lru_list[s][i + 1];
        i++;
      end
      lru_list[s][n - 1] = w;
    endfunction

    function void note_access(logic [OP_W-1:0] op, logic [ADDR_BITS-1:0] addr);
      result_t          r;
      int               s;
      logic [TAG_W-1:0] t;
      int               w;
      int               n;
      int               tm;
      int               nb;
      bit               found;
      r = '0;
      if (op != OP_READ && op != OP_WRITE) begin
        r.ignored = 1'b1;
        pending_results.push_back(r);
        return;
      end
      s = int'(addr[OFF_W +: SET_W]);
      t = addr[OFF_W + SET_W +: TAG_W];
      n = set_fill[s];
      found = 1'b0;
      w = 0;
      for (int i = 0; i < n; i++) begin
        if (!found && line_tag[s][i] == t) begin
          found = 1'b1;
          w = i;
        end
      end
      tm = cache_lat;
      nb = 0;
      if (found) begin
        if (op == OP_WRITE) begin
          if (!wr_hit_through) begin
            line_dirty[s][w] = 1'b1;
          end else begin
            nb += WORD_BYTES;
            tm += mem_lat;
          end
        end
        promote(s, w);
      end else if (op == OP_WRITE && wr_miss_bypass) begin
        nb += WORD_BYTES;
        tm += mem_lat;
      end else begin
        nb += LINE_BYTES;
        tm += OPS * mem_lat;
        if (n >= WAYS) begin
          w = lru_list[s][0];
          if (line_dirty[s][w]) begin
            r.dirty_eviction = 1'b1;
            nb += LINE_BYTES;
            tm += OPS * mem_lat;
          end
          for (int i = 0; i + 1 < WAYS; i++) lru_list[s][i] = lru_list[s][i + 1];
          lru_list[s][WAYS - 1] = w;
        end else begin
          w = n;
          lru_list[s][n] = n;
          set_fill[s] = n + 1;
        end
        line_tag[s][w] = t;
        line_dirty[s][w] = (op == OP_WRITE);
        tm += cache_lat;
      end
      r.hit = found;
      r.way_used = WAYU_W'(w);
      r.bytes_moved = BYTES_W'((nb > BYTES_SAT) ? BYTES_SAT : nb);
      r.access_time = TIME_W'((tm > TIME_SAT) ? TIME_SAT : tm);
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_W-1:0] word);
      result_t got;
      result_t want;
      got = word[$bits(result_t)-1:0];
      if (pending_results.size() == 0) begin
        $error("result word %h arrived with no access outstanding", word);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("hit", int'(want.hit), int'(got.hit));
      compare_field("ignored", int'(want.ignored), int'(got.ignored));
      compare_field("way_used", int'(want.way_used), int'(got.way_used));
      compare_field("dirty_eviction", int'(want.dirty_eviction), int'(got.dirty_eviction));
      compare_field("bytes_moved", int'(want.bytes_moved), int'(got.bytes_moved));
      compare_field("access_time", int'(want.access_time), int'(got.access_time));
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [ADDR_BITS-1:0]  in_tdata = '0;
  logic [OP_W-1:0]       in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  lru_cache_scoreboard sb = new();

  logic [SET_W-1:0] hot_sets [4];
  logic [TAG_W-1:0] hot_tags [6];
  int               rx_cycle = 0;
  int               rx_mode = 0;

  set_assoc_lru_cache_model DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_access(in_tuser, in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
    end
  end

  always @(posedge clk) begin
    if (rx_cycle % 200 == 0) rx_mode = $urandom_range(0, 3);
    rx_cycle++;
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= ($urandom_range(0, 7) != 0);
      default: out_tready <= ((rx_cycle % 16) < 5);
    endcase
  end

  task automatic send(logic [OP_W-1:0] op, logic [ADDR_BITS-1:0] addr);
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= addr;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic end_burst(int gap);
    in_tvalid <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(bit through, bit bypass, int cl, int ml);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom);
    d[0] = through;
    write_reg(REG_WR_HIT, d);
    d = CFG_DATA_W'($urandom);
    d[0] = bypass;
    write_reg(REG_WR_MISS, d);
    d = CFG_DATA_W'($urandom);
    d[CL_W-1:0] = CL_W'(cl);
    write_reg(REG_CL, d);
    write_reg(REG_ML, CFG_DATA_W'(ml));
  endtask

  task automatic drain();
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic refresh_pool();
    foreach (hot_sets[i]) hot_sets[i] = SET_W'($urandom);
    foreach (hot_tags[i]) hot_tags[i] = TAG_W'($urandom);
  endtask

  // Mostly accesses that revisit a few sets with a few tags, so that hits,
  // fills, evictions and dirty write-backs all occur; the rest is noise.
  task automatic make_access(output logic [OP_W-1:0] op, output logic [ADDR_BITS-1:0] addr);
    logic [SET_W-1:0] s;
    int               r;
    if ($urandom_range(0, 99) < 88) begin
      s = ($urandom_range(0, 4) == 0) ? SET_W'($urandom) : hot_sets[$urandom_range(0, 3)];
      addr = {hot_tags[$urandom_range(0, 5)], s, OFF_W'($urandom)};
      r = $urandom_range(0, 99);
      if (r < 46) op = OP_READ;
      else if (r < 92) op = OP_WRITE;
      else op = OP_W'($urandom_range(OP_OTHER, OP_OTHER_HI));
    end else begin
      addr = $urandom;
      op = OP_W'($urandom_range(0, 3));
    end
  endtask

  task automatic send_random(int count);
    logic [OP_W-1:0]      op;
    logic [ADDR_BITS-1:0] addr;
    int                   sent;
    int                   burst;
    sent = 0;
    refresh_pool();
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int j = 0; j < burst && sent < count; j++) begin
        make_access(op, addr);
        send(op, addr);
        sent++;
      end
      end_burst($urandom_range(1, 8));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: write-back, write-allocate.
    send(OP_READ, 32'h0000_0000);
    send(OP_READ, 32'h0000_001F);
    send(OP_WRITE, 32'h0000_0004);
    send(OP_READ, 32'h0000_1000);
    send(OP_READ, 32'h0000_2000);
    send(OP_READ, 32'h0000_3000);
    send(OP_READ, 32'h0000_4000);
    send(OP_WRITE, 32'h0000_5000);
    send(OP_READ, 32'h0000_1000);
    send(OP_WRITE, 32'h0000_5000);
    send(OP_OTHER, 32'hFFFF_FFFF);
    send(OP_OTHER_HI, 32'h0000_0000);
    send(OP_READ, 32'hFFFF_FFFF);
    send(OP_WRITE, 32'hFFFF_FFE0);
    send(OP_READ, 32'h0000_0FE0);
    end_burst(1);
    drain();
    send_random(125);
    drain();

    // Write-through, no-allocate, largest latencies.
    configure(1'b1, 1'b1, 1023, 4095);
    send(OP_WRITE, 32'hFFFF_FFFF);
    send(OP_WRITE, 32'h0000_7000);
    send(OP_READ, 32'h0000_7000);
    send(OP_WRITE, 32'h0000_4000);
    send(OP_READ, 32'h0000_1FE0);
    send(OP_READ, 32'h0000_2FE0);
    send(OP_READ, 32'h0000_3FE0);
    end_burst(1);
    send_random(125);
    drain();

    configure(1'b0, 1'b0, 0, 0);
    send_random(125);
    drain();

    configure(1'b0, 1'b1, $urandom_range(0, 1023), $urandom_range(0, 4095));
    send_random(125);
    drain();

    configure(1'b1, 1'b0, $urandom_range(0, 1023), $urandom_range(0, 4095));
    send_random(125);
    drain();

    configure(1'b0, 1'b0, int'(CL_RESET), int'(ML_RESET));
    send_random(125);
    drain();

    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
